/* hdl/odpp_pkg.sv */
package odpp_pkg;

  // field widths
  localparam int ColumnBits      = 12;
  localparam int ValueBits       = 21;
  localparam int FormatBits      = 5;
  localparam int RegionWidthBits = 13;
  localparam int PackedBits      = 32;
  localparam int BytesBits       = 3;
  localparam int ChanMaxBits     = 8;
  localparam int ShiftBits       = 5;
  localparam int ThreshBits      = 5;
  localparam int FixBits         = 17;
  localparam int NumChans        = 4;

  // configuration port
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 13;
  localparam logic [CfgIndexBits-1:0] CfgPixelFormat  = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgDitherEnable = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgRegionWidth  = 2'd2;

  // default for the widest destination rectangle
  localparam int MaxWidthDefault = 4096;

  // 1.0 in the channel fixed-point format
  localparam logic [FixBits-1:0] FixOne = 17'h10000;

  // output format codes
  localparam logic [FormatBits-1:0] FmtRgb888   = 5'd20;
  localparam logic [FormatBits-1:0] FmtArgb8888 = 5'd21;
  localparam logic [FormatBits-1:0] FmtXrgb8888 = 5'd22;
  localparam logic [FormatBits-1:0] FmtRgb565   = 5'd23;
  localparam logic [FormatBits-1:0] FmtXrgb1555 = 5'd24;
  localparam logic [FormatBits-1:0] FmtArgb1555 = 5'd25;
  localparam logic [FormatBits-1:0] FmtArgb4444 = 5'd26;

  // reset values of the registers
  localparam logic [FormatBits-1:0]      PixelFormatReset = FmtArgb8888;
  localparam logic [RegionWidthBits-1:0] RegionWidthReset = 13'd1;

  // half bias when dither is off
  localparam logic [ThreshBits-1:0] HalfThresh = 5'd16;

  // 4x4 ordered threshold, indexed [row mod 4][scan column mod 4], in 32nds
  localparam logic [ThreshBits-1:0] BayerThresh [4][4] = '{
    '{5'd31, 5'd15, 5'd27, 5'd11},
    '{5'd7,  5'd23, 5'd3,  5'd19},
    '{5'd25, 5'd9,  5'd29, 5'd13},
    '{5'd1,  5'd17, 5'd5,  5'd21}
  };

  typedef logic signed [ValueBits-1:0] chan_value_t;

  // one accepted pixel
  typedef struct packed {
    logic [ColumnBits-1:0] column;
    logic [ColumnBits-1:0] row;
    chan_value_t           red_value;
    chan_value_t           green_value;
    chan_value_t           blue_value;
    chan_value_t           alpha_value;
  } pixel_t;

  // layout of one channel in the packed word
  typedef struct packed {
    logic [ChanMaxBits-1:0] maxv;
    logic [ShiftBits-1:0]   shift;
  } chan_fmt_t;

  // layout of a whole format; chan order red, green, blue, alpha
  typedef struct packed {
    logic                       known;
    logic [BytesBits-1:0]       bytes;
    chan_fmt_t [NumChans-1:0]   chan;
  } fmt_info_t;

  function automatic chan_fmt_t chan_fmt(input int maxv, input int shift);
    chan_fmt_t cf;
    cf.maxv  = ChanMaxBits'(maxv);
    cf.shift = ShiftBits'(shift);
    return cf;
  endfunction

  function automatic fmt_info_t format_info(input logic [FormatBits-1:0] code);
    fmt_info_t fi;
    fi = '0;
    fi.known = 1'b1;
    case (code)
      FmtRgb888: begin
        fi.bytes = 3'd3;
        fi.chan  = {chan_fmt(0, 0), chan_fmt(255, 0), chan_fmt(255, 8), chan_fmt(255, 16)};
      end
      FmtArgb8888: begin
        fi.bytes = 3'd4;
        fi.chan  = {chan_fmt(255, 24), chan_fmt(255, 0), chan_fmt(255, 8),
                    chan_fmt(255, 16)};
      end
      FmtXrgb8888: begin
        fi.bytes = 3'd4;
        fi.chan  = {chan_fmt(0, 0), chan_fmt(255, 0), chan_fmt(255, 8), chan_fmt(255, 16)};
      end
      FmtRgb565: begin
        fi.bytes = 3'd2;
        fi.chan  = {chan_fmt(0, 0), chan_fmt(31, 0), chan_fmt(63, 5), chan_fmt(31, 11)};
      end
      FmtXrgb1555: begin
        fi.bytes = 3'd2;
        fi.chan  = {chan_fmt(0, 0), chan_fmt(31, 0), chan_fmt(31, 5), chan_fmt(31, 10)};
      end
      FmtArgb1555: begin
        fi.bytes = 3'd2;
        fi.chan  = {chan_fmt(1, 15), chan_fmt(31, 0), chan_fmt(31, 5), chan_fmt(31, 10)};
      end
      FmtArgb4444: begin
        fi.bytes = 3'd2;
        fi.chan  = {chan_fmt(15, 12), chan_fmt(15, 0), chan_fmt(15, 4), chan_fmt(15, 8)};
      end
      default: begin
        fi = '0;
      end
    endcase
    return fi;
  endfunction

endpackage

/* hdl/odpp_pixel_if.sv */
interface odpp_pixel_if;
  import odpp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ColumnBits-1:0] column;
  logic [ColumnBits-1:0] row;
  chan_value_t           red_value;
  chan_value_t           green_value;
  chan_value_t           blue_value;
  chan_value_t           alpha_value;

  modport source (
    output valid, column, row, red_value, green_value, blue_value, alpha_value,
    input  ready
  );

  modport sink (
    input  valid, column, row, red_value, green_value, blue_value, alpha_value,
    output ready
  );

endinterface

/* hdl/odpp_result_if.sv */
interface odpp_result_if;
  import odpp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PackedBits-1:0] packed_pixel;
  logic [BytesBits-1:0]  pixel_bytes;

  modport source (
    output valid, packed_pixel, pixel_bytes,
    input  ready
  );

  modport sink (
    input  valid, packed_pixel, pixel_bytes,
    output ready
  );

endinterface

/* hdl/odpp_cfg_if.sv */
interface odpp_cfg_if;
  import odpp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CfgIndexBits-1:0] index;
  logic [CfgDataBits-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

/* hdl/ordered_dither_pixel_packer_core.sv */
// Ordered-dither pixel packer.
// pixel:  one request per pixel: column and row in the destination rectangle
//         and four signed fixed-point channels (65536 is 1.0).
// result: one request per pixel: the packed format word and its byte count
//         (zero word and zero bytes for an unknown format code).
// cfg:    register writes (0 pixel_format, 1 dither_enable, 2 region_width),
//         always ready; write only while no pixel is in flight.
// Two register stages: an input register, then the result register with the
// quantize, dither and pack logic between them. Throughput is one pixel per
// cycle while result is not stalled, set by the single quantize stage with one
// small multiplier per channel.
// When result is stalled the pipeline holds; pixel.ready stays high while
// an empty stage remains, so up to two pixels are held during a stall.
// Reset empties both stages and loads format ARGB8888, dither off and
// region width 1.
module ordered_dither_pixel_packer_core #(
  parameter int MAX_WIDTH = odpp_pkg::MaxWidthDefault
) (
  input  logic          clk,
  input  logic          rst,
  odpp_cfg_if.sink      cfg,
  odpp_pixel_if.sink    pixel,
  odpp_result_if.source result
);
  import odpp_pkg::*;

  localparam int MaxWidthBits = $clog2(MAX_WIDTH + 1);
  localparam int CmpBits = (MaxWidthBits > RegionWidthBits) ? MaxWidthBits : RegionWidthBits;
  localparam logic [CmpBits-1:0] MaxWidthCmp = CmpBits'(MAX_WIDTH);
  localparam logic [1:0] MaxWidthLow = 2'(MAX_WIDTH % 4);

  // configuration registers
  logic [FormatBits-1:0]      pixel_format;
  logic                       dither_enable;
  logic [RegionWidthBits-1:0] region_width;

  // pipeline registers
  logic                  stage_valid;
  pixel_t                stage;
  logic                  out_valid;
  logic [PackedBits-1:0] out_packed;
  logic [BytesBits-1:0]  out_bytes;

  logic                  out_take;
  logic                  stage_take;
  logic [1:0]            width_low;
  logic [1:0]            scan;
  logic [ThreshBits-1:0] thresh;
  fmt_info_t             fmt;
  chan_value_t           chan_val [NumChans];
  logic [PackedBits-1:0] packed_next;

  // clamp to 0..1, scale by the channel maximum, add the threshold, floor
  function automatic logic [ChanMaxBits-1:0] quantize(
    input chan_value_t           raw,
    input logic [ChanMaxBits-1:0] maxv,
    input logic [ThreshBits-1:0]  thr
  );
    logic [FixBits-1:0]                 v;
    logic [FixBits+ChanMaxBits-1:0]     acc;
    logic [ChanMaxBits:0]               q;
    if (raw[ValueBits-1]) begin
      v = '0;
    end else if (raw[ValueBits-2:0] > (ValueBits-1)'(FixOne)) begin
      v = FixOne;
    end else begin
      v = raw[FixBits-1:0];
    end
    acc = (FixBits+ChanMaxBits)'(v) * (FixBits+ChanMaxBits)'(maxv)
        + (FixBits+ChanMaxBits)'({thr, 11'b0});
    q = acc[FixBits+ChanMaxBits-1:FixBits-1];
    return (q > {1'b0, maxv}) ? maxv : q[ChanMaxBits-1:0];
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= PixelFormatReset;
      dither_enable <= 1'b0;
      region_width  <= RegionWidthReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgPixelFormat:  pixel_format  <= cfg.data[FormatBits-1:0];
        CfgDitherEnable: dither_enable <= cfg.data[0];
        CfgRegionWidth:  region_width  <= cfg.data[RegionWidthBits-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_take    = !out_valid || result.ready;
  assign stage_take  = !stage_valid || out_take;
  assign pixel.ready = stage_take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_take) begin
      stage_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && pixel.valid) begin
      stage.column      <= pixel.column;
      stage.row         <= pixel.row;
      stage.red_value   <= pixel.red_value;
      stage.green_value <= pixel.green_value;
      stage.blue_value  <= pixel.blue_value;
      stage.alpha_value <= pixel.alpha_value;
    end
  end

  // low bits of the effective region width, clamped to 1..MAX_WIDTH
  always_comb begin
    if (region_width == '0) begin
      width_low = 2'd1;
    end else if (CmpBits'(region_width) > MaxWidthCmp) begin
      width_low = MaxWidthLow;
    end else begin
      width_low = region_width[1:0];
    end
  end

  // dither threshold, scan column mirrored on odd rows
  always_comb begin
    scan   = stage.row[0] ? (width_low - 2'd1 - stage.column[1:0]) : stage.column[1:0];
    thresh = dither_enable ? BayerThresh[stage.row[1:0]][scan] : HalfThresh;
  end

  // quantize and pack
  always_comb begin
    fmt         = format_info(pixel_format);
    chan_val[0] = stage.red_value;
    chan_val[1] = stage.green_value;
    chan_val[2] = stage.blue_value;
    chan_val[3] = stage.alpha_value;
    packed_next = '0;
    for (int c = 0; c < NumChans; c++) begin
      packed_next = packed_next
                  | (PackedBits'(quantize(chan_val[c], fmt.chan[c].maxv, thresh))
                     << fmt.chan[c].shift);
    end
    if (!fmt.known) begin
      packed_next = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && stage_valid) begin
      out_packed <= packed_next;
      out_bytes  <= fmt.bytes;
    end
  end

  assign result.valid        = out_valid;
  assign result.packed_pixel = out_packed;
  assign result.pixel_bytes  = out_bytes;

endmodule

/* tb/sv/odpp_packer_checker.sv */
module odpp_packer_checker #(
  parameter int MaxWidth = odpp_pkg::MaxWidthDefault
) (
  input  logic   clk,
  input  logic   rst,
  odpp_cfg_if    cfg,
  odpp_pixel_if  pixel,
  odpp_result_if result,
  output int     error_count,
  output int     words_due
);
  import odpp_pkg::*;

  typedef struct packed {
    logic [PackedBits-1:0] word;
    logic [BytesBits-1:0]  bytes;
  } packed_word_t;

  // own copy of the registers, tracked from the write requests
  logic [FormatBits-1:0]      fmt_reg;
  logic                       dither_reg;
  logic [RegionWidthBits-1:0] width_reg;

  packed_word_t pending_words [$];
  int           errors = 0;

  // quantize four channels and pack them for the current format
  function automatic packed_word_t pack_pixel(input pixel_t px);
    packed_word_t          res;
    logic [7:0]            chan_max [4];
    int                    chan_shift [4];
    chan_value_t           chan_val [4];
    logic [31:0]           span;
    logic [31:0]           scan;
    logic [ThreshBits-1:0] thr;
    logic [FixBits-1:0]    unit;
    logic [31:0]           scaled;
    res      = '0;
    chan_val = '{px.red_value, px.green_value, px.blue_value, px.alpha_value};
    case (fmt_reg)
      FmtRgb888: begin
        res.bytes  = 3'd3;
        chan_max   = '{255, 255, 255, 0};
        chan_shift = '{16, 8, 0, 0};
      end
      FmtArgb8888: begin
        res.bytes  = 3'd4;
        chan_max   = '{255, 255, 255, 255};
        chan_shift = '{16, 8, 0, 24};
      end
      FmtXrgb8888: begin
        res.bytes  = 3'd4;
        chan_max   = '{255, 255, 255, 0};
        chan_shift = '{16, 8, 0, 0};
      end
      FmtRgb565: begin
        res.bytes  = 3'd2;
        chan_max   = '{31, 63, 31, 0};
        chan_shift = '{11, 5, 0, 0};
      end
      FmtXrgb1555: begin
        res.bytes  = 3'd2;
        chan_max   = '{31, 31, 31, 0};
        chan_shift = '{10, 5, 0, 0};
      end
      FmtArgb1555: begin
        res.bytes  = 3'd2;
        chan_max   = '{31, 31, 31, 1};
        chan_shift = '{10, 5, 0, 15};
      end
      FmtArgb4444: begin
        res.bytes  = 3'd2;
        chan_max   = '{15, 15, 15, 15};
        chan_shift = '{8, 4, 0, 12};
      end
      default: begin
        // unknown code stores nothing
        return res;
      end
    endcase

    // width clamped to 1..MaxWidth, scan column mirrored on odd rows
    if (width_reg == '0)
      span = 32'd1;
    else if (width_reg > MaxWidth)
      span = 32'(MaxWidth);
    else
      span = 32'(width_reg);
    scan = px.row[0] ? span - 32'd1 - 32'(px.column) : 32'(px.column);
    thr  = dither_reg ? BayerThresh[px.row[1:0]][scan[1:0]] : HalfThresh;

    for (int c = 0; c < NumChans; c++) begin
      // saturate to 0..1.0 before scaling
      if (chan_val[c][ValueBits-1])
        unit = '0;
      else if (chan_val[c][ValueBits-2:0] > (ValueBits-1)'(FixOne))
        unit = FixOne;
      else
        unit = chan_val[c][FixBits-1:0];
      scaled = (32'(unit) * 32'(chan_max[c]) + (32'(thr) << 11)) >> 16;
      if (scaled > 32'(chan_max[c]))
        scaled = 32'(chan_max[c]);
      res.word |= scaled << chan_shift[c];
    end
    return res;
  endfunction

  // follow register writes, predict each pixel, compare each result
  always @(posedge clk) begin
    packed_word_t want;
    pixel_t       seen;
    if (rst) begin
      pending_words.delete();
      fmt_reg    = PixelFormatReset;
      dither_reg = 1'b0;
      width_reg  = RegionWidthReset;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CfgPixelFormat:  fmt_reg = cfg.data[FormatBits-1:0];
          CfgDitherEnable: dither_reg = cfg.data[0];
          CfgRegionWidth:  width_reg = cfg.data[RegionWidthBits-1:0];
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual packed_pixel %08h pixel_bytes %0d",
                   $time, result.packed_pixel, result.pixel_bytes);
        end else begin
          want = pending_words.pop_front();
          if (result.packed_pixel !== want.word) begin
            errors++;
            $display("%0t: packed_pixel mismatch, expected %08h, actual %08h",
                     $time, want.word, result.packed_pixel);
          end
          if (result.pixel_bytes !== want.bytes) begin
            errors++;
            $display("%0t: pixel_bytes mismatch, expected %0d, actual %0d",
                     $time, want.bytes, result.pixel_bytes);
          end
        end
      end

      if (pixel.valid && pixel.ready) begin
        seen.column      = pixel.column;
        seen.row         = pixel.row;
        seen.red_value   = pixel.red_value;
        seen.green_value = pixel.green_value;
        seen.blue_value  = pixel.blue_value;
        seen.alpha_value = pixel.alpha_value;
        pending_words.push_back(pack_pixel(seen));
      end
    end
    words_due   <= pending_words.size();
    error_count <= errors;
  end

endmodule

/* tb/sv/ordered_dither_pixel_packer_core_tb.sv */
module ordered_dither_pixel_packer_core_tb;
  import odpp_pkg::*;

  localparam int NumPhases      = 24;
  localparam int PixelsPerPhase = 58;
  localparam int HoldCycles     = 300;
  localparam int StallLimit     = 2000;
  localparam int SettleCycles   = 6;
  localparam int HoldPhase      = 9;
  localparam logic [CfgIndexBits-1:0] CfgSpare = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   error_count;
  int   words_due;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_now = 1'b0;

  logic [FormatBits-1:0] format_codes [7] = '{
    FmtRgb888, FmtArgb8888, FmtXrgb8888, FmtRgb565, FmtXrgb1555, FmtArgb1555, FmtArgb4444
  };
  chan_value_t corner_values [8] = '{
    21'sh100000, 21'sh0FFFFF, 21'sh1FFFFF, 21'sh000000,
    21'sh00FFFF, 21'sh010000, 21'sh010001, 21'sh008000
  };

  odpp_cfg_if    cfg_bus ();
  odpp_pixel_if  pixel_bus ();
  odpp_result_if result_bus ();

  ordered_dither_pixel_packer_core #(
    .MAX_WIDTH(MaxWidthDefault)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixel  (pixel_bus),
    .result (result_bus)
  );

  odpp_packer_checker #(
    .MaxWidth(MaxWidthDefault)
  ) packer_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_bus),
    .pixel       (pixel_bus),
    .result      (result_bus),
    .error_count (error_count),
    .words_due   (words_due)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on cycles with no request at all
  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_now) begin
        result_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_now = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
    end
  end

  // one register write request; valid is left high for a following write
  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
  endtask

  task automatic apply_settings(input logic [FormatBits-1:0] fmt, input logic dith,
                                input logic [RegionWidthBits-1:0] width);
    write_reg(CfgPixelFormat, CfgDataBits'(fmt));
    write_reg(CfgDitherEnable, CfgDataBits'(dith));
    write_reg(CfgRegionWidth, CfgDataBits'(width));
    // unused index must change nothing
    write_reg(CfgSpare, CfgDataBits'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  // one pixel request after a random gap
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_bus.valid       <= 1'b1;
    pixel_bus.column      <= px.column;
    pixel_bus.row         <= px.row;
    pixel_bus.red_value   <= px.red_value;
    pixel_bus.green_value <= px.green_value;
    pixel_bus.blue_value  <= px.blue_value;
    pixel_bus.alpha_value <= px.alpha_value;
    do @(posedge clk); while (!(pixel_bus.valid && pixel_bus.ready));
  endtask

  // drain the pipeline before touching the registers
  task automatic wait_idle;
    pixel_bus.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // mostly in-range channels, with saturating and corner values mixed in
  function automatic chan_value_t random_chan;
    case ($urandom_range(0, 9))
      0: return chan_value_t'($urandom);
      1: return corner_values[$urandom_range(0, 7)];
      2: return -chan_value_t'($urandom_range(1, 1 << (ValueBits - 1)));
      3: return chan_value_t'($urandom_range(32'(FixOne) + 1, (1 << (ValueBits - 1)) - 1));
      default: return chan_value_t'($urandom_range(0, 32'(FixOne)));
    endcase
  endfunction

  function automatic pixel_t random_pixel(input int span);
    pixel_t px;
    if ($urandom_range(0, 1))
      px.column = ColumnBits'($urandom_range(0, span - 1));
    else
      px.column = ColumnBits'($urandom);
    px.row         = ColumnBits'($urandom);
    px.red_value   = random_chan();
    px.green_value = random_chan();
    px.blue_value  = random_chan();
    px.alpha_value = random_chan();
    return px;
  endfunction

  // stimulus and verdict
  initial begin
    pixel_t                     px;
    logic [FormatBits-1:0]      fmt;
    logic                       dith;
    logic [RegionWidthBits-1:0] width;
    int                         span;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    pixel_bus.valid       <= 1'b0;
    pixel_bus.column      <= '0;
    pixel_bus.row         <= '0;
    pixel_bus.red_value   <= '0;
    pixel_bus.green_value <= '0;
    pixel_bus.blue_value  <= '0;
    pixel_bus.alpha_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // corner pixels under the reset settings
    for (int i = 0; i < 12; i++) begin
      px.column      = (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : ColumnBits'(i);
      px.row         = (i < 6) ? ColumnBits'(i) : ~ColumnBits'(i);
      px.red_value   = corner_values[i % 8];
      px.green_value = corner_values[(i + 3) % 8];
      px.blue_value  = corner_values[(i + 5) % 8];
      px.alpha_value = corner_values[(i + 7) % 8];
      send_pixel(px);
    end

    // phases over every format, dither mode and width extreme
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      if (phase % 8 < 7)
        fmt = format_codes[phase % 8];
      else if ($urandom_range(0, 1))
        fmt = FormatBits'($urandom_range(0, FmtRgb888 - 1));
      else
        fmt = FormatBits'($urandom_range(FmtArgb4444 + 1, (1 << FormatBits) - 1));
      dith = (phase < 8) ? 1'b0 : (phase < 16) ? 1'b1 : 1'($urandom);
      case (phase % 6)
        0: width = '0;
        1: width = RegionWidthBits'(1);
        2: width = RegionWidthBits'(MaxWidthDefault);
        3: width = ((phase / 6) % 2) ? '1 :
                   RegionWidthBits'($urandom_range(MaxWidthDefault + 1,
                                                   (1 << RegionWidthBits) - 1));
        4: width = RegionWidthBits'($urandom_range(2, 7));
        default: width = RegionWidthBits'($urandom_range(1, MaxWidthDefault));
      endcase
      span = (width == '0) ? 1 : (width > MaxWidthDefault) ? MaxWidthDefault : int'(width);
      apply_settings(fmt, dith, width);

      quiet = (phase % 5 == 2);
      if (phase == HoldPhase)
        hold_now = 1'b1;
      for (int n = 0; n < PixelsPerPhase; n++)
        send_pixel(random_pixel(span));
    end

    wait_idle();
    if (error_count == 0 && words_due == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
